>>> hw/rtl/rce_pkg.sv
// ----------------------------------------------------------------------------
// rce_pkg
// Shared types, codes and helpers for the row column extractor.
// ----------------------------------------------------------------------------
package rce_pkg;

    localparam int C_MAX_COLUMNS = 32;

    typedef enum logic [1:0] {
        COL_INT32  = 2'd0,
        COL_INT64  = 2'd1,
        COL_BOOL   = 2'd2,
        COL_STRING = 2'd3
    } t_col_type;

    typedef enum logic [1:0] {
        ST_VALUE   = 2'd0,
        ST_CORRUPT = 2'd1,
        ST_RANGE   = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CFG_COLUMN_TYPES  = 2'd0,
        CFG_COL_TOTAL     = 2'd1,
        CFG_WANTED_COLUMN = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic [5:0]  column_pos;
        logic [2:0]  field_bytes;
        logic        in_string;
        logic [31:0] string_left;
        logic [63:0] acc;
        logic        answered;
    } t_row_state;

    typedef struct packed {
        logic [63:0] column_types;
        logic [5:0]  col_total;
        logic [4:0]  wanted_column;
    } t_cfg;

    typedef struct packed {
        t_status     status;
        t_col_type   kind;
        logic [63:0] number;
        logic [31:0] string_length;
        logic        byte_valid;
        logic        value_last;
    } t_result;

    localparam t_row_state ROW_CLEAR = '0;

    // bytes in a fixed field, or in a string length header
    function automatic logic [3:0] field_size(input t_col_type ct);
        logic [3:0] sz;
        begin
            case (ct)
                COL_INT32:  sz = 4'd4;
                COL_INT64:  sz = 4'd8;
                COL_BOOL:   sz = 4'd1;
                default:    sz = 4'd4;
            endcase
            return sz;
        end
    endfunction

endpackage

>>> hw/rtl/rce_step.sv
// ----------------------------------------------------------------------------
// rce_step
// Per-byte row parser: next row state and the optional result word.
// ----------------------------------------------------------------------------
module rce_step #(
    parameter int MAX_COLUMNS = rce_pkg::C_MAX_COLUMNS
) (
    input  rce_pkg::t_row_state i_state,
    input  rce_pkg::t_cfg       i_cfg,
    input  logic [7:0]          i_row_byte,
    input  logic                i_row_end,
    output rce_pkg::t_row_state o_state,
    output rce_pkg::t_result    o_result,
    output logic                o_result_valid
);
    import rce_pkg::*;

    localparam logic [5:0] MaxCols = 6'(MAX_COLUMNS);

    logic [5:0]  count;
    logic [5:0]  type_idx;
    t_col_type   ctype;
    logic        hit;
    logic        final_given;
    logic [31:0] left_dec;
    logic [63:0] acc_new;
    logic [3:0]  bytes_inc;
    logic [63:0] value;

    assign count    = (i_cfg.col_total > MaxCols) ? MaxCols : i_cfg.col_total;
    assign type_idx = {i_state.column_pos[4:0], 1'b0};
    assign ctype    = t_col_type'(i_cfg.column_types[type_idx +: 2]);
    assign hit      = i_state.column_pos == {1'b0, i_cfg.wanted_column};
    assign left_dec = i_state.string_left - 32'd1;
    assign acc_new  = i_state.acc | (64'(i_row_byte) << {i_state.field_bytes, 3'b000});
    assign bytes_inc = {1'b0, i_state.field_bytes} + 4'd1;

    always_comb begin
        case (ctype)
            COL_INT32: value = {{32{acc_new[31]}}, acc_new[31:0]};
            COL_BOOL:  value = {63'd0, acc_new[7:0] != 8'd0};
            default:   value = acc_new;
        endcase
    end

    always_comb begin
        o_state        = i_state;
        o_result       = '0;
        o_result_valid = 1'b0;
        final_given    = 1'b0;

        if (i_state.answered) begin
            if (i_row_end) begin
                o_state = ROW_CLEAR;
            end
        end else if ({1'b0, i_cfg.wanted_column} >= count) begin
            o_result.status     = ST_RANGE;
            o_result.value_last = 1'b1;
            o_result_valid      = 1'b1;
            o_state.answered    = 1'b1;
            if (i_row_end) begin
                o_state = ROW_CLEAR;
            end
        end else begin
            if (ctype == COL_STRING && i_state.in_string) begin
                o_state.string_left = left_dec;
                if (hit) begin
                    o_result.status        = ST_VALUE;
                    o_result.kind          = COL_STRING;
                    o_result.number        = 64'(i_row_byte);
                    o_result.string_length = i_state.acc[31:0];
                    o_result.byte_valid    = 1'b1;
                    o_result.value_last    = left_dec == 32'd0;
                    o_result_valid         = 1'b1;
                    final_given            = left_dec == 32'd0;
                end else if (left_dec == 32'd0) begin
                    o_state            = ROW_CLEAR;
                    o_state.column_pos = i_state.column_pos + 6'd1;
                    o_state.answered   = i_state.answered;
                end
            end else begin
                o_state.acc         = acc_new;
                o_state.field_bytes = bytes_inc[2:0];
                if (bytes_inc >= field_size(ctype)) begin
                    if (ctype == COL_STRING) begin
                        if (acc_new[31:0] == 32'd0) begin
                            if (hit) begin
                                o_result.status     = ST_VALUE;
                                o_result.kind       = COL_STRING;
                                o_result.value_last = 1'b1;
                                o_result_valid      = 1'b1;
                                final_given         = 1'b1;
                            end else begin
                                o_state            = ROW_CLEAR;
                                o_state.column_pos = i_state.column_pos + 6'd1;
                                o_state.answered   = i_state.answered;
                            end
                        end else begin
                            o_state.field_bytes = 3'd0;
                            o_state.in_string   = 1'b1;
                            o_state.string_left = acc_new[31:0];
                        end
                    end else if (hit) begin
                        o_result.status     = ST_VALUE;
                        o_result.kind       = ctype;
                        o_result.number     = value;
                        o_result.byte_valid = 1'b1;
                        o_result.value_last = 1'b1;
                        o_result_valid      = 1'b1;
                        final_given         = 1'b1;
                    end else begin
                        o_state            = ROW_CLEAR;
                        o_state.column_pos = i_state.column_pos + 6'd1;
                        o_state.answered   = i_state.answered;
                    end
                end
            end

            if (final_given) begin
                o_state.answered = 1'b1;
            end
            if (i_row_end) begin
                if (!final_given) begin
                    o_result            = '0;
                    o_result.status     = ST_CORRUPT;
                    o_result.value_last = 1'b1;
                    o_result_valid      = 1'b1;
                end
                o_state = ROW_CLEAR;
            end
        end
    end

endmodule

>>> hw/rtl/row_column_extractor_unit.sv
// ----------------------------------------------------------------------------
// row_column_extractor_unit
// Extracts one configured column from a byte-serial length-prefixed row.
// ----------------------------------------------------------------------------
// Path from byte accept to result word: input register, then result register.
// Throughput: one row byte per cycle while the output is not stalled; the
// combinational parser step updates row state between the input register and the result register.
// Reset: synchronous, active low; clears row state, valids and config
// (column_types 0, column total 1, wanted_column 0).
module row_column_extractor_unit #(
    parameter int MAX_COLUMNS = rce_pkg::C_MAX_COLUMNS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [7:0]          i_row_byte,
    input  logic                i_row_end,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [1:0]          o_status,
    output logic [1:0]          o_value_kind,
    output logic signed [63:0]  o_number,
    output logic [31:0]         o_string_length,
    output logic                o_byte_valid,
    output logic                o_value_last,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [63:0]         i_cfg_data
);
    import rce_pkg::*;

    t_cfg       r_cfg;
    t_row_state r_state;
    t_row_state n_state;
    t_result    r_out;
    t_result    n_out;
    logic       n_out_valid;
    logic       r_out_valid;
    logic       r_in_valid;
    logic [7:0] r_row_byte;
    logic       r_row_end;
    logic       out_free;
    logic       step_go;
    logic       in_free;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign step_go    = r_in_valid && out_free;
    assign in_free    = !r_in_valid || step_go;
    assign o_in_stall = !in_free;
    assign o_cfg_ready = 1'b1;

    rce_step #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_step (
        .i_state        (r_state),
        .i_cfg          (r_cfg),
        .i_row_byte     (r_row_byte),
        .i_row_end      (r_row_end),
        .o_state        (n_state),
        .o_result       (n_out),
        .o_result_valid (n_out_valid)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.column_types  <= 64'd0;
            r_cfg.col_total     <= 6'd1;
            r_cfg.wanted_column <= 5'd0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_COLUMN_TYPES:  r_cfg.column_types  <= i_cfg_data;
                CFG_COL_TOTAL:     r_cfg.col_total     <= i_cfg_data[5:0];
                CFG_WANTED_COLUMN: r_cfg.wanted_column <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_free) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_free && i_in_valid) begin
            r_row_byte <= i_row_byte;
            r_row_end  <= i_row_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ROW_CLEAR;
            r_out_valid <= 1'b0;
        end else if (step_go) begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end else if (out_free) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_go && n_out_valid) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out.status;
    assign o_value_kind    = r_out.kind;
    assign o_number        = signed'(r_out.number);
    assign o_string_length = r_out.string_length;
    assign o_byte_valid    = r_out.byte_valid;
    assign o_value_last    = r_out.value_last;

endmodule

>>> verif/tb_row_column_extractor_unit.sv
// ----------------------------------------------------------------------------
// tb_row_column_extractor_unit
// Streams serialised rows byte by byte into the extractor under a series of
// schemas and checks every result word against an in-bench parser model.
// Covers all column types, sign extension, empty and truncated strings,
// out-of-range column selection, trailing bytes and random stall patterns.
// ----------------------------------------------------------------------------
module tb_row_column_extractor_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import rce_pkg::*;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} t_stall_mode;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [7:0]         i_row_byte;
    logic               i_row_end;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [1:0]         o_status;
    logic [1:0]         o_value_kind;
    logic signed [63:0] o_number;
    logic [31:0]        o_string_length;
    logic               o_byte_valid;
    logic               o_value_last;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index;
    logic [63:0]        i_cfg_data;

    row_column_extractor_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_row_byte      (i_row_byte),
        .i_row_end       (i_row_end),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_value_kind    (o_value_kind),
        .o_number        (o_number),
        .o_string_length (o_string_length),
        .o_byte_valid    (o_byte_valid),
        .o_value_last    (o_value_last),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // schema shadow
    logic [63:0] sch_types;
    logic [5:0]  sch_count;
    logic [4:0]  sch_wanted;

    // parser shadow
    logic [5:0]  col_pos;
    int          field_bytes;
    bit          in_payload;
    logic [31:0] payload_left;
    logic [63:0] field_acc;
    bit          row_done;

    t_result     expected_extracts[$];
    logic [7:0]  row_bytes[$];
    int          mismatch_count = 0;
    int          bytes_sent = 0;
    int          burst_left = 0;
    t_stall_mode stall_mode = STALL_NONE;
    int          stall_hold = 0;
    int          stall_tick = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("[row_column_extractor_unit] ERROR");
        $finish;
    end

    function automatic void clear_row();
        col_pos      = '0;
        field_bytes  = 0;
        in_payload   = 1'b0;
        payload_left = '0;
        field_acc    = '0;
        row_done     = 1'b0;
    endfunction

    function automatic void next_column();
        col_pos      = col_pos + 6'd1;
        field_bytes  = 0;
        in_payload   = 1'b0;
        payload_left = '0;
        field_acc    = '0;
    endfunction

    // one parser step; returns 1 when the byte yields a result word
    function automatic bit extract_step(input logic [7:0] b, input logic e, output t_result r);
        logic [5:0]  lim;
        logic [4:0]  pos;
        t_col_type   ct;
        bit          wanted;
        bit          got;
        bit          final_given;
        int          size;
        logic [63:0] v;
        logic [31:0] len;
        r = '0;
        got = 1'b0;
        final_given = 1'b0;
        lim = (sch_count > 6'd32) ? 6'd32 : sch_count;
        if (row_done) begin
            if (e) clear_row();
            return 1'b0;
        end
        if ({1'b0, sch_wanted} >= lim) begin
            r.status = ST_RANGE;
            r.value_last = 1'b1;
            row_done = 1'b1;
            if (e) clear_row();
            return 1'b1;
        end
        pos = col_pos[4:0];
        ct = t_col_type'(sch_types[2*pos +: 2]);
        wanted = (col_pos == {1'b0, sch_wanted});
        if (ct == COL_STRING && in_payload) begin
            len = field_acc[31:0];
            payload_left = payload_left - 32'd1;
            if (wanted) begin
                r.kind = COL_STRING;
                r.number = {56'd0, b};
                r.string_length = len;
                r.byte_valid = 1'b1;
                r.value_last = (payload_left == 0);
                got = 1'b1;
                final_given = (payload_left == 0);
            end else if (payload_left == 0) begin
                next_column();
            end
        end else begin
            size = (ct == COL_INT64) ? 8 : (ct == COL_BOOL) ? 1 : 4;
            field_acc = field_acc | ({56'd0, b} << ((8 * field_bytes) & 63));
            field_bytes++;
            if (field_bytes >= size) begin
                v = field_acc;
                if (ct == COL_STRING) begin
                    if (v[31:0] == 0) begin
                        if (wanted) begin
                            r.kind = COL_STRING;
                            r.value_last = 1'b1;
                            got = 1'b1;
                            final_given = 1'b1;
                        end else begin
                            next_column();
                        end
                    end else begin
                        field_bytes = 0;
                        in_payload = 1'b1;
                        payload_left = v[31:0];
                    end
                end else if (wanted) begin
                    if (ct == COL_INT32) v = {{32{v[31]}}, v[31:0]};
                    else if (ct == COL_BOOL) v = (v[7:0] != 0) ? 64'd1 : 64'd0;
                    r.kind = ct;
                    r.number = v;
                    r.byte_valid = 1'b1;
                    r.value_last = 1'b1;
                    got = 1'b1;
                    final_given = 1'b1;
                end else begin
                    next_column();
                end
            end
        end
        if (final_given) row_done = 1'b1;
        if (e) begin
            if (!final_given) begin
                r = '0;
                r.status = ST_CORRUPT;
                r.value_last = 1'b1;
                got = 1'b1;
            end
            clear_row();
        end
        return got;
    endfunction

    always @(posedge i_clk) begin : scoreboard
        t_result exp_r;
        if (!i_rst_n) begin
            sch_types  = '0;
            sch_count  = 6'd1;
            sch_wanted = '0;
            clear_row();
            expected_extracts.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_COLUMN_TYPES:  sch_types  = i_cfg_data;
                    CFG_COL_TOTAL:     sch_count  = i_cfg_data[5:0];
                    CFG_WANTED_COLUMN: sch_wanted = i_cfg_data[4:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !o_in_stall) begin
                if (extract_step(i_row_byte, i_row_end, exp_r)) expected_extracts.push_back(exp_r);
            end
            if (o_out_valid && !i_out_stall) begin
                if (expected_extracts.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected word: st=%0d kind=%0d num=%h len=%h bv=%b last=%b",
                                 o_status, o_value_kind, o_number, o_string_length,
                                 o_byte_valid, o_value_last);
                end else begin
                    exp_r = expected_extracts.pop_front();
                    if (o_status !== exp_r.status || o_value_kind !== exp_r.kind ||
                        o_number !== exp_r.number || o_string_length !== exp_r.string_length ||
                        o_byte_valid !== exp_r.byte_valid || o_value_last !== exp_r.value_last) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"word mismatch: exp st=%0d kind=%0d num=%h len=%h bv=%b ",
                                      "last=%b / got st=%0d kind=%0d num=%h len=%h bv=%b last=%b"},
                                     exp_r.status, exp_r.kind, exp_r.number, exp_r.string_length,
                                     exp_r.byte_valid, exp_r.value_last, o_status, o_value_kind,
                                     o_number, o_string_length, o_byte_valid, o_value_last);
                    end
                end
            end
        end
    end

    // output back-pressure, switching between patterns
    always @(posedge i_clk) begin
        if (stall_hold == 0) begin
            stall_mode <= t_stall_mode'($urandom_range(0, 3));
            stall_hold <= $urandom_range(40, 300);
        end else begin
            stall_hold <= stall_hold - 1;
        end
        stall_tick <= stall_tick + 1;
        case (stall_mode)
            STALL_NONE:  i_out_stall <= 1'b0;
            STALL_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: i_out_stall <= ($urandom_range(0, 9) < 7);
            default:     i_out_stall <= ((stall_tick % 5) < 2);
        endcase
    end

    task automatic send_byte(input logic [7:0] b, input logic e);
        int gap;
        if (burst_left == 0) begin
            if ($urandom_range(0, 5) == 0) begin
                burst_left = $urandom_range(60, 150);
                gap = 0;
            end else begin
                burst_left = $urandom_range(1, 24);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            end
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_row_byte <= b;
        i_row_end  <= e;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        burst_left--;
        bytes_sent++;
    endtask

    task automatic send_row();
        for (int i = 0; i < row_bytes.size(); i++)
            send_byte(row_bytes[i], i == row_bytes.size() - 1);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_extracts.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [63:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic apply_schema(input logic [63:0] types, input logic [5:0] count,
                                input logic [4:0] wanted);
        logic [63:0] d;
        wait_idle();
        write_reg(CFG_COLUMN_TYPES, types);
        d = {$urandom, $urandom};
        d[5:0] = count;
        write_reg(CFG_COL_TOTAL, d);
        d = {$urandom, $urandom};
        d[4:0] = wanted;
        write_reg(CFG_WANTED_COLUMN, d);
        i_cfg_valid <= 1'b0;
    endtask

    // serialise columns up to the wanted one, then bend the row at random (or send only random bytes)
    task automatic build_row(input logic [63:0] types, input int wanted);
        int          n;
        int          shape;
        bit          broken;
        t_col_type   ct;
        logic [31:0] len;
        logic [63:0] v;
        row_bytes.delete();
        broken = 1'b0;
        shape = $urandom_range(0, 9);
        if (shape == 0) begin
            n = $urandom_range(1, 6);
            repeat (n) row_bytes.push_back(8'($urandom));
            return;
        end
        for (int c = 0; c <= wanted && !broken; c++) begin
            ct = t_col_type'(types[2*c +: 2]);
            case (ct)
                COL_INT32, COL_INT64: begin
                    n = (ct == COL_INT32) ? 4 : 8;
                    case ($urandom_range(0, 9))
                        0: v = '0;
                        1: v = '1;
                        2: v = (ct == COL_INT32) ? 64'h8000_0000 : 64'h8000_0000_0000_0000;
                        3: v = (ct == COL_INT32) ? 64'h7fff_ffff : 64'h7fff_ffff_ffff_ffff;
                        default: v = {$urandom, $urandom};
                    endcase
                    for (int k = 0; k < n; k++) row_bytes.push_back(v[8*k +: 8]);
                end
                COL_BOOL: begin
                    row_bytes.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                                    : 8'($urandom_range(0, 1)));
                end
                default: begin
                    len = $urandom_range(0, 5);
                    if ($urandom_range(0, 7) == 0) len = $urandom_range(6, 24);
                    if ($urandom_range(0, 15) == 0) begin
                        len = $urandom;
                        broken = 1'b1;
                    end
                    for (int k = 0; k < 4; k++) row_bytes.push_back(len[8*k +: 8]);
                    n = broken ? $urandom_range(0, 3) : int'(len);
                    repeat (n) row_bytes.push_back(8'($urandom));
                end
            endcase
        end
        if (!broken) repeat ($urandom_range(0, 3)) row_bytes.push_back(8'($urandom));
        if (shape == 1 && row_bytes.size() > 1)
            row_bytes = row_bytes[0:$urandom_range(0, row_bytes.size() - 2)];
    endtask

    task automatic test_default_schema();
        row_bytes = '{8'h00, 8'h00, 8'h00, 8'h80};
        send_row();
    endtask

    task automatic test_number_extremes();
        apply_schema({62'd0, COL_INT64}, 6'd1, 5'd0);
        row_bytes = '{8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'h7f};
        send_row();
        apply_schema({62'd0, COL_BOOL}, 6'd1, 5'd0);
        row_bytes = '{8'hff};
        send_row();
    endtask

    task automatic test_string_cases();
        apply_schema({62'd0, COL_STRING}, 6'd1, 5'd0);
        row_bytes = '{8'h00, 8'h00, 8'h00, 8'h00};
        send_row();
        // row cut off inside the payload
        row_bytes = '{8'h03, 8'h00, 8'h00, 8'h00, 8'h41, 8'h42};
        send_row();
    endtask

    task automatic test_range_and_trailing();
        apply_schema({62'd0, COL_BOOL}, 6'd1, 5'd1);
        row_bytes = '{8'h5a};
        send_row();
        apply_schema({62'd0, COL_BOOL}, 6'd1, 5'd0);
        row_bytes = '{8'h00, 8'haa, 8'h01};
        send_row();
    endtask

    task automatic test_random_rows();
        logic [63:0] types;
        logic [5:0]  count;
        logic [4:0]  wanted;
        int          eff;
        int          phase_goal;
        while (bytes_sent < 1900) begin
            case ($urandom_range(0, 7))
                0: types = '0;
                1: types = '1;
                2: types = 64'haaaa_aaaa_aaaa_aaaa;
                3: types = 64'h5555_5555_5555_5555;
                default: types = {$urandom, $urandom};
            endcase
            case ($urandom_range(0, 11))
                0: count = 6'd1;
                1: count = 6'd32;
                2: count = $urandom_range(0, 1) ? 6'd0 : 6'($urandom_range(33, 63));
                3, 4: count = 6'($urandom_range(1, 32));
                default: count = 6'($urandom_range(1, 6));
            endcase
            eff = (count > 6'd32) ? 32 : int'(count);
            case ($urandom_range(0, 9))
                0: wanted = 5'd0;
                1: wanted = 5'd31;
                2: wanted = 5'($urandom_range(0, 31));
                3: wanted = (eff == 0) ? 5'd0 : 5'($urandom_range(0, eff - 1));
                default: wanted = (eff == 0) ? 5'd0
                                             : 5'($urandom_range(0, ((eff < 6) ? eff : 6) - 1));
            endcase
            apply_schema(types, count, wanted);
            phase_goal = bytes_sent + $urandom_range(40, 160);
            while (bytes_sent < phase_goal) begin
                build_row(types, int'(wanted));
                send_row();
            end
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_row_byte  <= '0;
        i_row_end   <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_COLUMN_TYPES;
        i_cfg_data  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_schema();
        test_number_extremes();
        test_string_cases();
        test_range_and_trailing();
        test_random_rows();
        wait_idle();
        if (mismatch_count == 0 && expected_extracts.size() == 0) begin
            $display("[row_column_extractor_unit] OK");
        end else begin
            $display("[row_column_extractor_unit] ERROR");
        end
        $finish;
    end

endmodule

>>> files.f
hw/rtl/rce_pkg.sv
hw/rtl/rce_step.sv
hw/rtl/row_column_extractor_unit.sv
verif/tb_row_column_extractor_unit.sv
